// ----- rtl/cursor_hash_fifo_cache_top_macros.svh -----
// Assertion macros for the cursor hash cache.
// Taken in by the top level, which writes its assertions with them.
`ifndef CURSOR_HASH_FIFO_CACHE_TOP_MACROS_SVH
`define CURSOR_HASH_FIFO_CACHE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define CHFC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define CHFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/chfc_pkg.sv -----
// Package for the cursor hash cache: codes, constants and the types
// shared by the cache cells and the top level. No dependencies.
`default_nettype none

package chfc_pkg;

    localparam int unsigned HASH_W = 32;
    localparam int unsigned SLOT_W = 5;

    localparam logic [HASH_W-1:0] HASH_SEED = 32'd5381;
    localparam logic signed [15:0] MAX_SIDE = 16'sd16383;
    localparam logic signed [15:0] MIN_SIDE = 16'sd1;

    localparam logic [1:0] OUT_FOUND = 2'd0;
    localparam logic [1:0] OUT_NEW   = 2'd1;
    localparam logic [1:0] OUT_BAD   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_SEARCH,
        ST_DONE
    } t_state;

    // Lookup token that walks down the row of cells.
    typedef struct packed {
        logic              act;
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } t_token;

    // Per-cell control from the top level.
    typedef struct packed {
        logic              used;
        logic              wr;
        logic [HASH_W-1:0] wr_data;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ----- rtl/chfc_cell.sv -----
// One cache cell: holds a stored hash and one stage of the lookup token.
// Depends on chfc_pkg.
`default_nettype none

module chfc_cell import chfc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [HASH_W-1:0] i_key,
    input  wire t_token            i_tok,
    input  wire t_cell_ctl         i_ctl,
    output t_token                 o_tok,
    output logic      [HASH_W-1:0] o_entry
);

    logic [HASH_W-1:0] r_entry;
    t_token            r_tok;
    t_token            n_tok;
    logic              w_match;

    always_comb begin
        w_match    = i_tok.act && !i_tok.hit && i_ctl.used && (r_entry == i_key);
        n_tok.act  = i_tok.act;
        n_tok.hit  = i_tok.hit || w_match;
        n_tok.slot = (i_tok.hit || w_match) ? i_tok.slot : i_tok.slot + SLOT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_entry <= i_ctl.wr_data;
        end
    end

    assign o_tok   = r_tok;
    assign o_entry = r_entry;

endmodule

`default_nettype wire

// ----- rtl/cursor_hash_fifo_cache_top.sv -----
// Cursor hash cache top level: DJB2 hashing, size check and a FIFO cache
// built as a row of chfc_cell instances. Depends on chfc_pkg and the macros header.
//
// Usage:
// The input channel carries one image byte per transaction, with a last-byte
// flag and the cursor width and height, which are examined on the last byte.
// Bytes that are not last are folded into the hash at one per cycle and give
// no result. A last byte gives exactly one result transaction on the output
// channel: found (with slot), new entry stored (with a reset request when the
// cache was empty) or invalid size, always with the image hash.
// Lookup: a token walks the row of CACHE_ENTRIES cells, one cell per cycle;
// a last byte with a valid size goes through START, SEARCH and DONE before its
// result is registered, an invalid size goes straight to DONE. Input ready stays
// low from the last byte until its result is loaded into the output register.
// The output register frees the input side: new bytes are taken while a
// result waits. If the receiver stalls, a further last byte waits in the
// final lookup step until the output register empties.
// Reset empties the cache, reloads the hash seed and clears the output valid.
`default_nettype none

`include "cursor_hash_fifo_cache_top_macros.svh"

module cursor_hash_fifo_cache_top import chfc_pkg::*; #(
    parameter int unsigned CACHE_ENTRIES = 30
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_image_byte,
    input  wire logic        i_last_byte,
    input  wire logic [15:0] i_cursor_width,
    input  wire logic [15:0] i_cursor_height,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_outcome,
    output logic [4:0]       o_cache_slot,
    output logic             o_cache_clear,
    output logic [31:0]      o_image_hash
);

    localparam int unsigned CNT_W = $clog2(CACHE_ENTRIES + 1);

    t_state            r_state;
    t_state            n_state;
    logic [HASH_W-1:0] r_acc;
    logic [HASH_W-1:0] r_key;
    logic              r_bad;
    logic              r_hit;
    logic [SLOT_W-1:0] r_slot;
    logic [CNT_W-1:0]  r_count;
    logic              r_out_valid;
    logic [1:0]        r_outcome;
    logic [SLOT_W-1:0] r_cache_slot;
    logic              r_cache_clear;
    logic [HASH_W-1:0] r_image_hash;

    logic              w_accept;
    logic              w_inject;
    logic              w_fire;
    logic              w_upd;
    logic              w_full;
    logic              w_size_ok;
    logic [HASH_W-1:0] w_hash;

    t_token            w_tok   [CACHE_ENTRIES+1];
    t_cell_ctl         w_ctl   [CACHE_ENTRIES];
    logic [HASH_W-1:0] w_entry [CACHE_ENTRIES];

    assign w_hash = {r_acc[HASH_W-6:0], 5'b0} + r_acc + {24'b0, i_image_byte};
    assign w_size_ok = ($signed(i_cursor_width) >= MIN_SIDE)
                    && ($signed(i_cursor_width) <= MAX_SIDE)
                    && ($signed(i_cursor_height) >= MIN_SIDE)
                    && ($signed(i_cursor_height) <= MAX_SIDE);
    assign w_full = (r_count == CNT_W'(CACHE_ENTRIES));
    assign w_accept = i_in_valid && o_in_ready;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        w_inject   = 1'b0;
        w_fire     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid && i_last_byte) begin
                    n_state = w_size_ok ? ST_START : ST_DONE;
                end
            end
            ST_START: begin
                w_inject = 1'b1;
                n_state  = ST_SEARCH;
            end
            ST_SEARCH: begin
                if (w_tok[CACHE_ENTRIES].act) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    w_fire  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign w_upd = w_fire && !r_bad && !r_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_acc       <= HASH_SEED;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_acc <= i_last_byte ? HASH_SEED : w_hash;
            end
            if (w_upd && !w_full) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_last_byte) begin
            r_key <= w_hash;
            r_bad <= !w_size_ok;
        end
        if (r_state == ST_SEARCH && w_tok[CACHE_ENTRIES].act) begin
            r_hit  <= w_tok[CACHE_ENTRIES].hit;
            r_slot <= w_tok[CACHE_ENTRIES].slot;
        end
        if (w_fire) begin
            r_image_hash <= r_key;
            if (r_bad) begin
                r_outcome     <= OUT_BAD;
                r_cache_slot  <= '0;
                r_cache_clear <= 1'b0;
            end else if (r_hit) begin
                r_outcome     <= OUT_FOUND;
                r_cache_slot  <= r_slot;
                r_cache_clear <= 1'b0;
            end else begin
                r_outcome     <= OUT_NEW;
                r_cache_slot  <= (r_count == '0) ? SLOT_W'(CACHE_ENTRIES) : '0;
                r_cache_clear <= (r_count == '0);
            end
        end
    end

    assign w_tok[0] = '{act: w_inject, hit: 1'b0, slot: '0};

    for (genvar i = 0; i < CACHE_ENTRIES; i++) begin : g_cell
        assign w_ctl[i].used = (CNT_W'(i) < r_count);
        assign w_ctl[i].wr   = w_upd && (w_full || (r_count == CNT_W'(i)));
        if (i == CACHE_ENTRIES - 1) begin : g_tail
            assign w_ctl[i].wr_data = r_key;
        end else begin : g_body
            assign w_ctl[i].wr_data = w_full ? w_entry[i+1] : r_key;
        end

        chfc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_key   (r_key),
            .i_tok   (w_tok[i]),
            .i_ctl   (w_ctl[i]),
            .o_tok   (w_tok[i+1]),
            .o_entry (w_entry[i])
        );
    end

    assign o_out_valid   = r_out_valid;
    assign o_outcome     = r_outcome;
    assign o_cache_slot  = r_cache_slot;
    assign o_cache_clear = r_cache_clear;
    assign o_image_hash  = r_image_hash;

    `CHFC_ASSERT_IMPL(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(CACHE_ENTRIES), "Entry count exceeds the cache size.")
    `CHFC_ASSERT_IMPL(a_idle_no_token, i_clk, i_rst_n, r_state == ST_IDLE, !w_tok[CACHE_ENTRIES].act, "Lookup token active while idle.")
    `CHFC_ASSERT_IMPL(a_reset_is_new, i_clk, i_rst_n, o_out_valid && o_cache_clear, o_outcome == OUT_NEW, "Cache reset signalled without a new entry.")
    `CHFC_ASSERT_NEXT(a_last_blocks, i_clk, i_rst_n, w_accept && i_last_byte, !o_in_ready, "Input ready after a last byte before its result.")

endmodule

`default_nettype wire
